/* src/tdpt_pkg.sv */
// ---------------------------------------------------------------------------
// tdpt_pkg: shared constants and types of the primality tester
// Widths of the candidate, the trial divisor, its square and the bit counter
// of the serial remainder unit, and the status bundle that unit returns.
// ---------------------------------------------------------------------------
package tdpt_pkg;

  localparam int NumberWidth = 32;
  localparam int DivWidth    = NumberWidth / 2 + 1;
  localparam int SqWidth     = NumberWidth + 2;
  localparam int CountWidth  = $clog2(NumberWidth);

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_status_t;

endpackage

/* src/tdpt_rem.sv */
// ---------------------------------------------------------------------------
// tdpt_rem: bit-serial remainder unit
// Restoring division that shifts one dividend bit per cycle into a narrow
// partial remainder, and reports whether the final remainder is zero.
// ---------------------------------------------------------------------------
module tdpt_rem (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [tdpt_pkg::NumberWidth-1:0]    dividend,
  input  logic [tdpt_pkg::DivWidth-1:0]       divisor,
  output tdpt_pkg::rem_status_t               status
);
  import tdpt_pkg::*;

  logic [NumberWidth-1:0] dvd_r, dvd_nxt;
  logic [DivWidth-1:0]    div_r, div_nxt;
  logic [DivWidth-1:0]    rem_r, rem_nxt;
  logic [CountWidth-1:0]  cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [DivWidth:0]      trial;
  logic [DivWidth:0]      diff;

  always_comb begin
    trial    = {rem_r, dvd_r[NumberWidth-1]};
    diff     = trial - {1'b0, div_r};
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CountWidth'(NumberWidth - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[NumberWidth-2:0], 1'b0};
      if (!diff[DivWidth]) begin
        rem_nxt = diff[DivWidth-1:0];
      end else begin
        rem_nxt = trial[DivWidth-1:0];
      end
      cnt_nxt = cnt_r - CountWidth'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign status.zero = (rem_r == '0);

endmodule

/* src/trial_division_prime_test.sv */
// ---------------------------------------------------------------------------
// trial_division_prime_test: trial-division primality tester
// A request carries one unsigned candidate; the result says whether it is
// prime. Odd divisors from three upward are tried while their square does not
// exceed the candidate, each through a bit-serial remainder unit.
// Usage: in_valid/in_stall and out_valid/out_stall form the two channels; a
// request moves at an edge with valid high and stall low. One request is
// worked on at a time, and in_stall is high from acceptance until the result
// is placed in the output register. Zero, one, two and even candidates need
// no division and go straight from acceptance to the finishing state. Every
// odd divisor tried takes a square compare, a pass through the bit-serial
// remainder unit and a step to collect its answer. A prime near the top of
// the range tries 32767 divisors. The result waits in the output register
// while out_stall is high, and a new request is taken meanwhile; a finished
// test waits for the register to be free. Reset empties the output register
// and returns the block to idle.
// ---------------------------------------------------------------------------
module trial_division_prime_test (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_candidate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_prime
);
  import tdpt_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCheck = 2'd1;
  localparam logic [1:0] StDiv   = 2'd2;
  localparam logic [1:0] StFin   = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [NumberWidth-1:0] cand_r, cand_nxt;
  logic [DivWidth-1:0]    div_r, div_nxt;
  logic [SqWidth-1:0]     sq_r, sq_nxt;
  logic                   res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_prime_r, out_prime_nxt;
  logic                   rem_start;
  logic [NumberWidth-1:0] in_num;
  rem_status_t            rem_st;

  assign in_num = NumberWidth'(in_candidate);

  tdpt_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (cand_r),
    .divisor  (div_r),
    .status   (rem_st)
  );

  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    div_nxt       = div_r;
    sq_nxt        = sq_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;
    rem_start     = 1'b0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      StIdle: begin
        if (in_valid) begin
          cand_nxt = in_num;
          div_nxt  = DivWidth'(3);
          sq_nxt   = SqWidth'(9);
          if (in_num[NumberWidth-1:1] == '0 || !in_num[0]) begin
            res_nxt   = (in_num == NumberWidth'(2));
            state_nxt = StFin;
          end else begin
            state_nxt = StCheck;
          end
        end
      end
      StCheck: begin
        if (sq_r <= {2'b00, cand_r}) begin
          rem_start = 1'b1;
          state_nxt = StDiv;
        end else begin
          res_nxt   = 1'b1;
          state_nxt = StFin;
        end
      end
      StDiv: begin
        if (rem_st.done) begin
          if (rem_st.zero) begin
            res_nxt   = 1'b0;
            state_nxt = StFin;
          end else begin
            div_nxt   = div_r + DivWidth'(2);
            sq_nxt    = sq_r + SqWidth'({div_r, 2'b00}) + SqWidth'(4);
            state_nxt = StCheck;
          end
        end
      end
      StFin: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = res_r;
          state_nxt     = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cand_r      <= cand_nxt;
    div_r       <= div_nxt;
    sq_r        <= sq_nxt;
    res_r       <= res_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign in_stall     = (state_r != StIdle) || !rst_n;
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;

  a_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
    rem_start |-> !rem_st.busy)
    else $error("remainder unit started while busy");

  a_div_odd : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StCheck || state_r == StDiv) |-> div_r[0])
    else $error("trial divisor is even");

  a_zero_composite : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StDiv && rem_st.done && rem_st.zero) |=> (state_r == StFin && !res_r))
    else $error("zero remainder not reported as composite");

  a_fin_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StFin && out_valid_r && out_stall) |=> (state_r == StFin && $stable(res_r)))
    else $error("finished result lost while output register full");

endmodule

/* sim/testbench.sv */
// ---------------------------------------------------------------------------
// Testbench for trial_division_prime_test
// Each request carries a candidate number. The scoreboard works out by its own
// trial division whether that candidate is prime, and it checks every result
// against the oldest outstanding verdict. Directed requests cover the trivial
// and boundary candidates and the largest 32-bit prime. Random requests are
// mostly small candidates or large composites with a small factor, so that
// the run stays short. Both sides pause and stall at random.
// ---------------------------------------------------------------------------

typedef struct {
  logic [31:0] candidate;
  bit          is_prime;
} verdict_t;

class PrimeScoreboard;
  verdict_t verdicts[$];
  int       errors;

  function bit primality(logic [31:0] number);
    longint unsigned n;
    longint unsigned d;
    n = number & ((64'd1 << tdpt_pkg::NumberWidth) - 1);
    if (n <= 1) return 1'b0;
    if (n == 2) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void note_request(logic [31:0] number);
    verdict_t v;
    v.candidate = number;
    v.is_prime  = primality(number);
    verdicts.push_back(v);
  endfunction

  function void check_result(logic got);
    verdict_t v;
    if (verdicts.size() == 0) begin
      $display("%0t: result %0b arrived with no request outstanding", $time, got);
      errors++;
    end else begin
      v = verdicts.pop_front();
      if (got !== v.is_prime) begin
        $display("%0t: candidate %0d: expected is_prime %0b, got %0b",
                 $time, v.candidate, v.is_prime, got);
        errors++;
      end
    end
  endfunction

  function int outstanding();
    return verdicts.size();
  endfunction
endclass

module testbench;

  localparam int RandomRequests = 100;
  localparam int unsigned SmallFactors[8] = '{3, 5, 7, 11, 13, 17, 19, 23};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_candidate;
  logic        out_valid;
  logic        out_stall;
  logic        out_is_prime;

  bit             quiet;
  PrimeScoreboard board = new();

  trial_division_prime_test DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_candidate(in_candidate),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_is_prime(out_is_prime)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function logic [31:0] random_candidate();
    int unsigned factor;
    int unsigned cofactor;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, 64);
    if (r < 50) return $urandom_range(0, 32'h3FFFF);
    if (r < 75) return $urandom() & 32'hFFFF_FFFE;
    factor   = SmallFactors[$urandom_range(0, 7)];
    cofactor = $urandom_range(0, (32'hFFFF_FFFF / factor - 1) / 2) * 2 + 1;
    return factor * cofactor;
  endfunction

  task automatic send_request(input logic [31:0] number);
    int gap;
    in_valid     <= 1'b1;
    in_candidate <= number;
    do @(posedge clk); while (in_stall);
    board.note_request(number);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int hold;
    out_stall <= 1'b0;
    wait (rst_n);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_is_prime);
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_candidate <= '0;
    quiet        = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(32'd0);
    send_request(32'd1);
    send_request(32'd2);
    send_request(32'd3);
    send_request(32'd4);
    send_request(32'd5);
    send_request(32'd7);
    send_request(32'd9);
    send_request(32'd15);
    send_request(32'd25);
    send_request(32'd49);
    send_request(32'd97);
    send_request(32'd65521);
    send_request(32'd1000003);
    send_request(32'h8000_0000);
    send_request(32'hFFFF_FFFE);
    send_request(32'hFFFF_FFFF);
    send_request(32'hAAAA_AAAB);
    // The largest 32-bit prime, where the square of the next divisor no
    // longer fits in 32 bits.
    send_request(32'd4294967291);

    for (int i = 0; i < RandomRequests; i++) begin
      quiet = ((i / 20) % 2) == 1;
      send_request(random_candidate());
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (board.outstanding() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
